// ===== hdl/arp_pkg.sv =====
package arp_pkg;

  localparam int PILE_DEPTH = 48;
  localparam int STEP_DEPTH = 256;
  localparam int POS_SPAN = 48;

  localparam int PILE_AW = $clog2(PILE_DEPTH);
  localparam int PILE_CW = $clog2(PILE_DEPTH + 1);
  localparam int STEP_AW = $clog2(STEP_DEPTH);
  localparam int STEP_CW = $clog2(STEP_DEPTH + 1);
  localparam int STEP_W = 8;

  // Beat number is clock_count / 24 = (clock_count >> 3) / 3, the divide by
  // three done as a multiply by 2^33 / 3 rounded up, then a shift by 33.
  localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;
  localparam int RECIP_SHIFT = 33;
  localparam int PROD_W = 29 + 32;
  localparam int BEAT_W = 28;

  localparam logic [2:0] PAT_UP = 3'd0;
  localparam logic [2:0] PAT_DOWN = 3'd1;
  localparam logic [2:0] PAT_UPDOWN = 3'd2;
  localparam logic [2:0] PAT_PLAYED = 3'd3;
  localparam logic [2:0] PAT_CONVERGE = 3'd4;
  localparam logic [2:0] PAT_PEDAL = 3'd5;

  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_OCTAVE = 2'd1;
  localparam logic [1:0] REG_QSTART = 2'd2;

  localparam logic [1:0] ES_IDLE = 2'd0;
  localparam logic [1:0] ES_WAITING = 2'd1;
  localparam logic [1:0] ES_PLAYING = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        pos_ok;
    logic [5:0]  pos;
    logic [31:0] clk_count;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] pos;
    logic [1:0] oct;
    logic [1:0] state;
    logic [5:0] held;
  } result_t;

  typedef struct packed {
    logic mark_stale;
    logic clear_await;
  } cfg_evt_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_ADD_CHK,
    ST_ADD_SH_RD,
    ST_ADD_SH_WR,
    ST_ADD_FIN,
    ST_RM_RD,
    ST_RM_USE,
    ST_RM_FIN,
    ST_TK_MUL,
    ST_TK_EVAL,
    ST_RB_INIT,
    ST_RB_PED_RD,
    ST_RB_PED,
    ST_RB_RD,
    ST_RB_WR,
    ST_RB_WR2,
    ST_RB_TAIL,
    ST_UD_RD,
    ST_UD_WR,
    ST_RB_DONE,
    ST_PLAY,
    ST_PLAY_RD,
    ST_RESULT
  } eng_state_t;

  // Octave number of a stored step (value / 48).
  function automatic logic [2:0] step_oct(input logic [STEP_W-1:0] v);
    logic [2:0] q;
    if (v >= 8'd240) q = 3'd5;
    else if (v >= 8'd192) q = 3'd4;
    else if (v >= 8'd144) q = 3'd3;
    else if (v >= 8'd96) q = 3'd2;
    else if (v >= 8'd48) q = 3'd1;
    else q = 3'd0;
    return q;
  endfunction

endpackage

// ===== hdl/arp_front.sv =====
module arp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [1:0]        operation,
  input  logic [5:0]        pad_position,
  input  logic [31:0]       clock_count,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output arp_pkg::item_t    item
);

  arp_pkg::item_t slots [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;
  arp_pkg::item_t incoming;
  logic do_push;
  logic do_pop;

  // Classify on entry so the engine branches on decoded fields.
  always_comb begin
    incoming.op = arp_pkg::op_t'(operation);
    incoming.pos_ok = (pad_position < 6'(arp_pkg::POS_SPAN));
    incoming.pos = pad_position;
    incoming.clk_count = clock_count;
  end

  assign full = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign item = slots[rp];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== hdl/arp_outq.sv =====
module arp_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  arp_pkg::result_t  din,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output arp_pkg::result_t  dout
);

  arp_pkg::result_t slots [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;
  logic do_push;
  logic do_pop;

  assign full = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout = slots[rp];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== hdl/arp_engine.sv =====
module arp_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  arp_pkg::item_t     in_item,
  output logic               in_pop,
  input  logic [2:0]         pattern_mode,
  input  logic [2:0]         octave_span,
  input  logic               qstart,
  input  arp_pkg::cfg_evt_t  cfg_evt,
  input  logic               out_full,
  output logic               out_push,
  output arp_pkg::result_t   out_res
);

  localparam int PAW = arp_pkg::PILE_AW;
  localparam int PCW = arp_pkg::PILE_CW;
  localparam int SAW = arp_pkg::STEP_AW;
  localparam int SCW = arp_pkg::STEP_CW;
  localparam int SW = arp_pkg::STEP_W;

  arp_pkg::eng_state_t state;
  arp_pkg::eng_state_t state_next;

  // Memories.
  logic [5:0] sorted_mem [arp_pkg::PILE_DEPTH];
  logic [5:0] arrival_mem [arp_pkg::PILE_DEPTH];
  logic [SW-1:0] store_mem [arp_pkg::STEP_DEPTH];
  logic [5:0] sorted_q;
  logic [5:0] arrival_q;
  logic [SW-1:0] store_q;
  logic [PAW-1:0] pile_ra;
  logic sorted_we;
  logic [PAW-1:0] sorted_wa;
  logic [5:0] sorted_wd;
  logic arrival_we;
  logic [PAW-1:0] arrival_wa;
  logic [5:0] arrival_wd;
  logic [SAW-1:0] store_ra;
  logic store_we;
  logic [SAW-1:0] store_wa;
  logic [SW-1:0] store_wd;

  // Control and working registers.
  arp_pkg::item_t cur;
  logic [PCW-1:0] size;
  logic [SCW-1:0] count;
  logic [SAW-1:0] ptr;
  logic ptr_valid;
  logic stale;
  logic running;
  logic awaiting;
  logic [arp_pkg::BEAT_W-1:0] last_q;
  logic last_unset;
  logic [PCW-1:0] idx;
  logic [PCW-1:0] at;
  logic found_s;
  logic found_a;
  logic [2:0] oct;
  logic [SCW-1:0] k;
  logic [SCW-1:0] total;
  logic [SCW-1:0] uk;
  logic [5:0] pedal;
  logic [SW-1:0] enc_r;
  logic [arp_pkg::PROD_W-1:0] prod;
  logic res_valid;
  logic [5:0] res_pos;
  logic [1:0] res_oct;

  // Derived values.
  logic [5:0] src_q;
  logic [SW-1:0] enc;
  logic [SCW-1:0] span_total;
  logic [SCW-1:0] half;
  logic [SCW-1:0] wr_addr;
  logic [SCW-1:0] k_rev;
  logic [arp_pkg::BEAT_W-1:0] beat_q;
  logic [SAW-1:0] ptr_n;
  logic [SCW-1:0] ptr_inc;
  logic [2:0] dec_q;
  logic [SW-1:0] dec_pos;
  logic is_pedal;
  logic rb_last;
  logic rb_wrap;
  logic ped_room;
  logic add_dup;
  logic add_before;
  logic add_last;
  logic tk_play;

  assign src_q = (pattern_mode == arp_pkg::PAT_PLAYED) ? arrival_q : sorted_q;
  assign enc = SW'(src_q) + SW'(oct * arp_pkg::POS_SPAN);
  assign is_pedal = (pattern_mode == arp_pkg::PAT_PEDAL);

  always_comb begin
    logic [SCW+3:0] prodt;
    prodt = (SCW + 4)'(octave_span) * (SCW + 4)'(size);
    if (prodt > (SCW + 4)'(arp_pkg::STEP_DEPTH)) span_total = SCW'(arp_pkg::STEP_DEPTH);
    else span_total = prodt[SCW-1:0];
  end

  assign half = (total + SCW'(1)) >> 1;
  assign k_rev = total - SCW'(1) - k;

  // Down writes the ascending list back to front; converge interleaves
  // the low end (even slots) with the high end (odd slots).
  always_comb begin
    case (pattern_mode)
      arp_pkg::PAT_DOWN: wr_addr = k_rev;
      arp_pkg::PAT_CONVERGE: begin
        if (k < half) wr_addr = k << 1;
        else wr_addr = (k_rev << 1) + SCW'(1);
      end
      default: wr_addr = k;
    endcase
  end

  assign beat_q = prod[arp_pkg::RECIP_SHIFT +: arp_pkg::BEAT_W];

  assign ptr_inc = SCW'(ptr) + SCW'(1);
  always_comb begin
    if (!ptr_valid || ptr_inc >= count) ptr_n = '0;
    else ptr_n = ptr_inc[SAW-1:0];
  end

  assign dec_q = arp_pkg::step_oct(store_q);
  assign dec_pos = store_q - SW'(dec_q * arp_pkg::POS_SPAN);

  assign rb_last = is_pedal ? (oct == octave_span) : (k == total);
  assign rb_wrap = (idx == size);
  assign ped_room = ((count + SCW'(2)) <= SCW'(arp_pkg::STEP_DEPTH));

  assign add_dup = (sorted_q == cur.pos);
  assign add_before = (cur.pos < sorted_q);
  assign add_last = (PCW'(idx + PCW'(1)) == size);

  assign tk_play = (size != '0) && running &&
                   (!awaiting || (!last_unset && (beat_q > last_q)));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      arp_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_item.op)
            arp_pkg::OP_ADD: begin
              if (!in_item.pos_ok) state_next = arp_pkg::ST_RESULT;
              else if (size == '0) state_next = arp_pkg::ST_ADD_FIN;
              else state_next = arp_pkg::ST_ADD_RD;
            end
            arp_pkg::OP_REMOVE: begin
              if (!in_item.pos_ok || size == '0) state_next = arp_pkg::ST_RESULT;
              else state_next = arp_pkg::ST_RM_RD;
            end
            arp_pkg::OP_CLEAR: state_next = arp_pkg::ST_RESULT;
            default: state_next = arp_pkg::ST_TK_MUL;
          endcase
        end
      end
      arp_pkg::ST_ADD_RD: state_next = arp_pkg::ST_ADD_CMP;
      arp_pkg::ST_ADD_CMP: begin
        if (add_dup) state_next = arp_pkg::ST_RESULT;
        else if (add_before || add_last) state_next = arp_pkg::ST_ADD_CHK;
        else state_next = arp_pkg::ST_ADD_RD;
      end
      arp_pkg::ST_ADD_CHK: begin
        if (size >= PCW'(arp_pkg::PILE_DEPTH)) state_next = arp_pkg::ST_RESULT;
        else if (size == at) state_next = arp_pkg::ST_ADD_FIN;
        else state_next = arp_pkg::ST_ADD_SH_RD;
      end
      arp_pkg::ST_ADD_SH_RD: state_next = arp_pkg::ST_ADD_SH_WR;
      arp_pkg::ST_ADD_SH_WR: begin
        if (PCW'(idx - PCW'(1)) == at) state_next = arp_pkg::ST_ADD_FIN;
        else state_next = arp_pkg::ST_ADD_SH_RD;
      end
      arp_pkg::ST_ADD_FIN: state_next = arp_pkg::ST_RESULT;
      arp_pkg::ST_RM_RD: state_next = arp_pkg::ST_RM_USE;
      arp_pkg::ST_RM_USE: begin
        if (add_last) state_next = arp_pkg::ST_RM_FIN;
        else state_next = arp_pkg::ST_RM_RD;
      end
      arp_pkg::ST_RM_FIN: state_next = arp_pkg::ST_RESULT;
      arp_pkg::ST_TK_MUL: state_next = arp_pkg::ST_TK_EVAL;
      arp_pkg::ST_TK_EVAL: begin
        if (!tk_play) state_next = arp_pkg::ST_RESULT;
        else if (stale) state_next = arp_pkg::ST_RB_INIT;
        else state_next = arp_pkg::ST_PLAY;
      end
      arp_pkg::ST_RB_INIT: begin
        if (size == '0) state_next = arp_pkg::ST_RB_DONE;
        else if (is_pedal) state_next = arp_pkg::ST_RB_PED_RD;
        else state_next = arp_pkg::ST_RB_RD;
      end
      arp_pkg::ST_RB_PED_RD: state_next = arp_pkg::ST_RB_PED;
      arp_pkg::ST_RB_PED: state_next = arp_pkg::ST_RB_RD;
      arp_pkg::ST_RB_RD: begin
        if (rb_last) begin
          if (is_pedal) state_next = arp_pkg::ST_RB_TAIL;
          else if (pattern_mode == arp_pkg::PAT_UPDOWN && total > SCW'(2))
            state_next = arp_pkg::ST_UD_RD;
          else state_next = arp_pkg::ST_RB_DONE;
        end else if (rb_wrap) begin
          state_next = arp_pkg::ST_RB_RD;
        end else if (is_pedal && !ped_room) begin
          state_next = arp_pkg::ST_RB_DONE;
        end else begin
          state_next = arp_pkg::ST_RB_WR;
        end
      end
      arp_pkg::ST_RB_WR: begin
        if (is_pedal) state_next = arp_pkg::ST_RB_WR2;
        else state_next = arp_pkg::ST_RB_RD;
      end
      arp_pkg::ST_RB_WR2: state_next = arp_pkg::ST_RB_RD;
      arp_pkg::ST_RB_TAIL: state_next = arp_pkg::ST_RB_DONE;
      arp_pkg::ST_UD_RD: begin
        if (uk < SCW'(2) || count >= SCW'(arp_pkg::STEP_DEPTH))
          state_next = arp_pkg::ST_RB_DONE;
        else state_next = arp_pkg::ST_UD_WR;
      end
      arp_pkg::ST_UD_WR: state_next = arp_pkg::ST_UD_RD;
      arp_pkg::ST_RB_DONE: state_next = arp_pkg::ST_PLAY;
      arp_pkg::ST_PLAY: begin
        if (count == '0) state_next = arp_pkg::ST_RESULT;
        else state_next = arp_pkg::ST_PLAY_RD;
      end
      arp_pkg::ST_PLAY_RD: state_next = arp_pkg::ST_RESULT;
      arp_pkg::ST_RESULT: begin
        if (!out_full) state_next = arp_pkg::ST_IDLE;
      end
      default: state_next = arp_pkg::ST_IDLE;
    endcase
  end

  // Outputs and memory ports.
  always_comb begin
    in_pop = 1'b0;
    out_push = 1'b0;
    pile_ra = '0;
    sorted_we = 1'b0;
    sorted_wa = '0;
    sorted_wd = sorted_q;
    arrival_we = 1'b0;
    arrival_wa = '0;
    arrival_wd = arrival_q;
    store_ra = '0;
    store_we = 1'b0;
    store_wa = '0;
    store_wd = enc;
    case (state)
      arp_pkg::ST_IDLE: in_pop = in_valid;
      arp_pkg::ST_ADD_RD: pile_ra = idx[PAW-1:0];
      arp_pkg::ST_ADD_SH_RD: pile_ra = PAW'(idx - PCW'(1));
      arp_pkg::ST_ADD_SH_WR: begin
        sorted_we = 1'b1;
        sorted_wa = idx[PAW-1:0];
      end
      arp_pkg::ST_ADD_FIN: begin
        sorted_we = 1'b1;
        sorted_wa = at[PAW-1:0];
        sorted_wd = cur.pos;
        arrival_we = 1'b1;
        arrival_wa = size[PAW-1:0];
        arrival_wd = cur.pos;
      end
      arp_pkg::ST_RM_RD: pile_ra = idx[PAW-1:0];
      arp_pkg::ST_RM_USE: begin
        // Once the position is found, each later entry moves down one.
        sorted_we = found_s && (idx != '0);
        sorted_wa = PAW'(idx - PCW'(1));
        arrival_we = found_a && (idx != '0);
        arrival_wa = PAW'(idx - PCW'(1));
      end
      arp_pkg::ST_RB_RD: begin
        if (idx < PCW'(arp_pkg::PILE_DEPTH)) pile_ra = idx[PAW-1:0];
      end
      arp_pkg::ST_RB_WR: begin
        store_we = 1'b1;
        if (is_pedal) begin
          store_wa = count[SAW-1:0];
          store_wd = SW'(pedal);
        end else begin
          store_wa = wr_addr[SAW-1:0];
        end
      end
      arp_pkg::ST_RB_WR2: begin
        store_we = 1'b1;
        store_wa = SAW'(count + SCW'(1));
        store_wd = enc_r;
      end
      arp_pkg::ST_RB_TAIL: begin
        store_we = (count == '0);
        store_wd = SW'(pedal);
      end
      arp_pkg::ST_UD_RD: store_ra = SAW'(uk - SCW'(1));
      arp_pkg::ST_UD_WR: begin
        store_we = 1'b1;
        store_wa = count[SAW-1:0];
        store_wd = store_q;
      end
      arp_pkg::ST_PLAY: store_ra = ptr_n;
      arp_pkg::ST_RESULT: out_push = !out_full;
      default: ;
    endcase
  end

  always_comb begin
    out_res.valid = res_valid;
    out_res.pos = res_pos;
    out_res.oct = res_oct;
    if (size == '0 || !running) out_res.state = arp_pkg::ES_IDLE;
    else if (awaiting) out_res.state = arp_pkg::ES_WAITING;
    else out_res.state = arp_pkg::ES_PLAYING;
    out_res.held = 6'(size);
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (sorted_we) sorted_mem[sorted_wa] <= sorted_wd;
    sorted_q <= sorted_mem[pile_ra];
  end

  always_ff @(posedge clk) begin
    if (arrival_we) arrival_mem[arrival_wa] <= arrival_wd;
    arrival_q <= arrival_mem[pile_ra];
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_wa] <= store_wd;
    store_q <= store_mem[store_ra];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arp_pkg::ST_IDLE;
      size <= '0;
      count <= '0;
      ptr_valid <= 1'b0;
      stale <= 1'b0;
      running <= 1'b0;
      awaiting <= 1'b0;
      last_q <= '0;
      last_unset <= 1'b1;
    end else begin
      state <= state_next;
      case (state)
        arp_pkg::ST_IDLE: begin
          if (in_valid) begin
            cur <= in_item;
            idx <= '0;
            at <= '0;
            found_s <= 1'b0;
            found_a <= 1'b0;
            res_valid <= 1'b0;
            res_pos <= '0;
            res_oct <= '0;
            if (in_item.op == arp_pkg::OP_CLEAR) begin
              size <= '0;
              count <= '0;
              stale <= 1'b0;
              ptr_valid <= 1'b0;
              running <= 1'b0;
              awaiting <= 1'b0;
            end
          end
        end
        arp_pkg::ST_ADD_CMP: begin
          if (add_before) at <= idx;
          else if (add_last) at <= size;
          else idx <= PCW'(idx + PCW'(1));
        end
        arp_pkg::ST_ADD_CHK: idx <= size;
        arp_pkg::ST_ADD_SH_WR: idx <= PCW'(idx - PCW'(1));
        arp_pkg::ST_ADD_FIN: begin
          size <= PCW'(size + PCW'(1));
          stale <= 1'b1;
          if (size == '0 || !running) begin
            running <= 1'b1;
            if (qstart) begin
              awaiting <= 1'b1;
              last_unset <= 1'b1;
            end
          end
        end
        arp_pkg::ST_RM_USE: begin
          if (sorted_q == cur.pos) found_s <= 1'b1;
          if (arrival_q == cur.pos) found_a <= 1'b1;
          idx <= PCW'(idx + PCW'(1));
        end
        arp_pkg::ST_RM_FIN: begin
          if (found_a) begin
            size <= PCW'(size - PCW'(1));
            stale <= 1'b1;
          end
        end
        arp_pkg::ST_TK_MUL: begin
          prod <= arp_pkg::PROD_W'(cur.clk_count[31:3]) * arp_pkg::PROD_W'(arp_pkg::RECIP_3);
        end
        arp_pkg::ST_TK_EVAL: begin
          if (size == '0 || !running) begin
            running <= 1'b0;
          end else if (awaiting) begin
            last_q <= beat_q;
            if (last_unset) last_unset <= 1'b0;
            else if (beat_q > last_q) awaiting <= 1'b0;
          end
        end
        arp_pkg::ST_RB_INIT: begin
          count <= '0;
          k <= '0;
          oct <= '0;
          idx <= '0;
          total <= span_total;
        end
        arp_pkg::ST_RB_PED: begin
          pedal <= src_q;
          idx <= PCW'(1);
        end
        arp_pkg::ST_RB_RD: begin
          if (rb_last) begin
            if (!is_pedal) begin
              count <= total;
              uk <= total - SCW'(1);
            end
          end else if (rb_wrap) begin
            idx <= '0;
            oct <= oct + 3'd1;
          end
        end
        arp_pkg::ST_RB_WR: begin
          idx <= PCW'(idx + PCW'(1));
          k <= k + SCW'(1);
          enc_r <= enc;
        end
        arp_pkg::ST_RB_WR2: count <= count + SCW'(2);
        arp_pkg::ST_RB_TAIL: begin
          if (count == '0) count <= SCW'(1);
        end
        arp_pkg::ST_UD_WR: begin
          count <= count + SCW'(1);
          uk <= uk - SCW'(1);
        end
        arp_pkg::ST_RB_DONE: begin
          stale <= 1'b0;
          if (ptr_valid && SCW'(ptr) >= count) ptr_valid <= 1'b0;
        end
        arp_pkg::ST_PLAY: begin
          if (count != '0) begin
            ptr <= ptr_n;
            ptr_valid <= 1'b1;
          end
        end
        arp_pkg::ST_PLAY_RD: begin
          res_valid <= 1'b1;
          res_pos <= dec_pos[5:0];
          res_oct <= dec_q[1:0];
        end
        default: ;
      endcase
      if (cfg_evt.mark_stale) stale <= 1'b1;
      if (cfg_evt.clear_await) awaiting <= 1'b0;
    end
  end

endmodule

// ===== hdl/arpeggiator_step_sequencer.sv =====
// Every request (clear, remove, add or tick) ends in one result on the ports.
// A tick that plays on a stale sequence rebuilds it first; in up-down the
// rebuild also writes the returning steps, and pedal up writes a pedal pair
// per step instead.
// The engine takes one request at a time; the pile and step memories each
// have one read and one write port.
// Reset (rst, synchronous) clears queues, counters and flags; memories keep
// their contents, which are never used before being written.
module arpeggiator_step_sequencer (
  input  logic        clk,
  input  logic        rst,
  // Request side.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [5:0]  pad_position,
  input  logic [31:0] clock_count,
  // Result side.
  output logic        empty,
  input  logic        pop,
  output logic        step_valid,
  output logic [5:0]  step_position,
  output logic [1:0]  step_octave,
  output logic [1:0]  engine_state,
  output logic [5:0]  held_count,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] pattern_mode;
  logic [2:0] octave_span;
  logic beat_quantized_start;
  logic cfg_wr;
  logic [1:0] cfg_idx;
  logic [2:0] span_clamped;
  arp_pkg::cfg_evt_t cfg_evt;

  logic item_valid;
  logic item_pop;
  arp_pkg::item_t item;
  logic res_push;
  logic res_full;
  arp_pkg::result_t res_in;
  arp_pkg::result_t res_out;

  // The port never waits, so a write lands on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  // Octave span is held in the range one to four.
  always_comb begin
    if (pwdata[2:0] < 3'd1) span_clamped = 3'd1;
    else if (pwdata[2:0] > 3'd4) span_clamped = 3'd4;
    else span_clamped = pwdata[2:0];
  end

  // A real change of pattern or span forces a rebuild at the next playing
  // tick; turning off the quantized start drops any wait for a beat.
  always_comb begin
    cfg_evt.mark_stale = 1'b0;
    cfg_evt.clear_await = 1'b0;
    if (cfg_wr) begin
      case (cfg_idx)
        arp_pkg::REG_PATTERN: cfg_evt.mark_stale = (pwdata[2:0] != pattern_mode);
        arp_pkg::REG_OCTAVE: cfg_evt.mark_stale = (span_clamped != octave_span);
        arp_pkg::REG_QSTART: cfg_evt.clear_await = !pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= arp_pkg::PAT_UP;
      octave_span <= 3'd1;
      beat_quantized_start <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        arp_pkg::REG_PATTERN: pattern_mode <= pwdata[2:0];
        arp_pkg::REG_OCTAVE: octave_span <= span_clamped;
        arp_pkg::REG_QSTART: beat_quantized_start <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      arp_pkg::REG_PATTERN: prdata = {29'd0, pattern_mode};
      arp_pkg::REG_OCTAVE: prdata = {29'd0, octave_span};
      arp_pkg::REG_QSTART: prdata = {31'd0, beat_quantized_start};
      default: prdata = '0;
    endcase
  end

  // Front end: a two-entry request queue that decodes each request.
  arp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .operation    (operation),
    .pad_position (pad_position),
    .clock_count  (clock_count),
    .full         (full),
    .pop          (item_pop),
    .valid        (item_valid),
    .item         (item)
  );

  // Back end: pile upkeep, beat gating, sequence rebuild and stepping.
  arp_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (item_valid),
    .in_item      (item),
    .in_pop       (item_pop),
    .pattern_mode (pattern_mode),
    .octave_span  (octave_span),
    .qstart       (beat_quantized_start),
    .cfg_evt      (cfg_evt),
    .out_full     (res_full),
    .out_push     (res_push),
    .out_res      (res_in)
  );

  // Result queue, so the engine moves on while a result waits to be taken.
  arp_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign step_valid = res_out.valid;
  assign step_position = res_out.pos;
  assign step_octave = res_out.oct;
  assign engine_state = res_out.state;
  assign held_count = res_out.held;

endmodule
